[rtl/rgb_to_hsv_converter_core_assert.svh]
// Assertion macros for the converter core.
// Both expect clk and arst_n in scope where they are used.
`ifndef RGB_TO_HSV_CONVERTER_CORE_ASSERT_SVH
`define RGB_TO_HSV_CONVERTER_CORE_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define RHC_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked outside reset.
`define RHC_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[rtl/rhc_pkg.sv]
package rhc_pkg;

	// Quotient bits per division; one cell per bit
	localparam int DIV_STEPS = 15;

	// Full hue circle in 1/64 degree units
	localparam logic [14:0] HUE_CIRCLE = 15'd23040;

	// Input beat: one pixel
	typedef struct packed {
		logic [7:0] red_in;
		logic [7:0] green_in;
		logic [7:0] blue_in;
	} pix_t;

	// Output beat: one HSV result
	typedef struct packed {
		logic [14:0] hue_out;
		logic [7:0]  sat_out;
		logic [7:0]  val_out;
	} hsv_t;

	// One restoring-division lane: partial remainder, numerator bits
	// still to bring down with quotient bits shifted in, and divisor
	typedef struct packed {
		logic [8:0]  rem;
		logic [14:0] nq;
		logic [8:0]  div;
	} lane_t;

	// Everything a cell hands to its neighbor
	typedef struct packed {
		lane_t      hue;
		lane_t      sat;
		logic [7:0] val;
	} cell_data_t;

endpackage

[rtl/rgb_to_hsv_converter_core.sv]
// Channel | Direction | Handshake                | Beat
// pix     | in        | pix_valid / pix_stall    | pix_t: red_in, green_in, blue_in
// hsv     | out       | hsv_valid / hsv_stall    | hsv_t: hue_out, sat_out, val_out
//
// One pixel per clock unless a stalled result holds the chain; two prep stages, fifteen
// division cells (one quotient bit each for hue and saturation), one output register.
// Reset clears only the valid bits of every stage; payload is not reset.
// A stalled result freezes the whole chain, so pix_stall follows hsv_stall
// while a result is waiting; bubbles flow through otherwise.
`include "rgb_to_hsv_converter_core_assert.svh"

module rgb_to_hsv_converter_core (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          pix_valid,
	output logic          pix_stall,
	input  rhc_pkg::pix_t pix,
	output logic          hsv_valid,
	input  logic          hsv_stall,
	output rhc_pkg::hsv_t hsv
);
	import rhc_pkg::*;

	logic       en;
	logic       cell_valid [0:DIV_STEPS];
	cell_data_t cell_data  [0:DIV_STEPS];
	logic       out_black;

	// Chain advances unless a result sits stalled at the output
	assign en        = !(hsv_valid && hsv_stall);
	assign pix_stall = !en;

	rhc_prep u_prep (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.valid_in (pix_valid),
		.pix_in   (pix),
		.valid_s2 (cell_valid[0]),
		.data_s2  (cell_data[0])
	);

	// Division chain, one quotient bit per cell
	for (genvar i = 0; i < DIV_STEPS; i++) begin : g_cell
		rhc_div_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.en       (en),
			.valid_in (cell_valid[i]),
			.data_in  (cell_data[i]),
			.valid_q  (cell_valid[i+1]),
			.data_q   (cell_data[i+1])
		);
	end

	rhc_out u_out (
		.clk         (clk),
		.arst_n      (arst_n),
		.en          (en),
		.valid_in    (cell_valid[DIV_STEPS]),
		.data_in     (cell_data[DIV_STEPS]),
		.hsv_valid_q (hsv_valid),
		.hsv_q       (hsv)
	);

	// Valid result of a black pixel
	assign out_black = hsv_valid && (hsv.val_out == 8'd0);

	// Hue stays inside the circle
	`RHC_ASSERT_NOW(a_hue_range, hsv_valid, hsv.hue_out < HUE_CIRCLE, "hue out of range")
	// Black pixel gives zero hue and saturation
	`RHC_ASSERT_NOW(a_black, out_black, {hsv.sat_out, hsv.hue_out} == 23'd0, "black not zero")
	// Zero saturation means grey, so hue is zero
	`RHC_ASSERT_NOW(a_grey, hsv_valid && hsv.sat_out == 8'd0, hsv.hue_out == 15'd0, "grey with hue")
	// A beat leaving the last cell while the chain moves shows at the output
	`RHC_ASSERT_NEXT(a_drain, en && cell_valid[DIV_STEPS], hsv_valid, "result lost at output")

endmodule

[rtl/rhc_div_cell.sv]
module rhc_div_cell (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               en,
	input  logic               valid_in,
	input  rhc_pkg::cell_data_t data_in,
	output logic               valid_q,
	output rhc_pkg::cell_data_t data_q
);
	import rhc_pkg::*;

	lane_t hue_next;
	lane_t sat_next;

	// One restoring step: bring down a bit, subtract if it fits
	function automatic lane_t div_step(input lane_t l);
		logic [9:0] t;
		logic [9:0] diff;
		logic       ge;
		lane_t      r;
		t    = {l.rem, l.nq[DIV_STEPS-1]};
		diff = t - {1'b0, l.div};
		ge   = (t >= {1'b0, l.div});
		r.rem = ge ? diff[8:0] : t[8:0];
		r.nq  = {l.nq[DIV_STEPS-2:0], ge};
		r.div = l.div;
		return r;
	endfunction

	always_comb begin
		hue_next = div_step(data_in.hue);
		sat_next = div_step(data_in.sat);
	end

	// Valid bit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (en) begin
			valid_q <= valid_in;
		end
	end

	// Payload
	always_ff @(posedge clk) begin
		if (en) begin
			data_q.hue <= hue_next;
			data_q.sat <= sat_next;
			data_q.val <= data_in.val;
		end
	end

endmodule

[rtl/rhc_prep.sv]
module rhc_prep (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                en,
	input  logic                valid_in,
	input  rhc_pkg::pix_t       pix_in,
	output logic                valid_s2,
	output rhc_pkg::cell_data_t data_s2
);
	import rhc_pkg::*;

	logic [7:0]         mx;
	logic [7:0]         mn;
	logic [7:0]         delta;
	logic signed [11:0] num;
	logic signed [11:0] num_wrap;

	logic        valid_s1;
	logic [7:0]  val_s1;
	logic [7:0]  delta_s1;
	logic [10:0] unum_s1;

	logic [23:0] num_hue;
	logic [23:0] num_sat;

	// Max, min and sector numerator; red wins ties, then green
	always_comb begin
		mx = pix_in.red_in;
		mn = pix_in.red_in;
		if (pix_in.green_in > mx) mx = pix_in.green_in;
		if (pix_in.blue_in > mx)  mx = pix_in.blue_in;
		if (pix_in.green_in < mn) mn = pix_in.green_in;
		if (pix_in.blue_in < mn)  mn = pix_in.blue_in;
		delta = mx - mn;
		if (pix_in.red_in == mx) begin
			num = $signed({4'b0, pix_in.green_in}) - $signed({4'b0, pix_in.blue_in});
		end else if (pix_in.green_in == mx) begin
			num = $signed({3'b0, delta, 1'b0}) + $signed({4'b0, pix_in.blue_in})
				- $signed({4'b0, pix_in.red_in});
		end else begin
			num = $signed({2'b0, delta, 2'b0}) + $signed({4'b0, pix_in.red_in})
				- $signed({4'b0, pix_in.green_in});
		end
		// Negative hue wraps by a full circle (six sectors)
		num_wrap = (num < 0) ? num + $signed({2'b0, delta, 2'b0}) + $signed({3'b0, delta, 1'b0})
			: num;
	end

	// Stage 1
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else if (en) begin
			valid_s1 <= valid_in;
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			val_s1   <= mx;
			delta_s1 <= delta;
			unum_s1  <= num_wrap[10:0];
		end
	end

	// Rounded-division numerators: 7680*unum + delta and 510*delta + max
	always_comb begin
		num_hue = (24'(unum_s1) << 13) - (24'(unum_s1) << 9) + 24'(delta_s1);
		num_sat = (24'(delta_s1) << 9) - (24'(delta_s1) << 1) + 24'(val_s1);
	end

	// Stage 2: load both division lanes; zero divisors become one (numerator is zero then)
	always_ff @(posedge clk) begin
		if (en) begin
			data_s2.hue.rem <= num_hue[23:DIV_STEPS];
			data_s2.hue.nq  <= num_hue[DIV_STEPS-1:0];
			data_s2.hue.div <= (delta_s1 == 8'd0) ? 9'd1 : {delta_s1, 1'b0};
			data_s2.sat.rem <= num_sat[23:DIV_STEPS];
			data_s2.sat.nq  <= num_sat[DIV_STEPS-1:0];
			data_s2.sat.div <= (val_s1 == 8'd0) ? 9'd1 : {val_s1, 1'b0};
			data_s2.val     <= val_s1;
		end
	end

endmodule

[rtl/rhc_out.sv]
module rhc_out (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                en,
	input  logic                valid_in,
	input  rhc_pkg::cell_data_t data_in,
	output logic                hsv_valid_q,
	output rhc_pkg::hsv_t       hsv_q
);
	import rhc_pkg::*;

	logic [14:0] hue_quot;
	logic [14:0] hue_wrapped;

	// Quotient of the hue lane, wrapped at the full circle
	always_comb begin
		hue_quot    = data_in.hue.nq;
		hue_wrapped = (hue_quot >= HUE_CIRCLE) ? hue_quot - HUE_CIRCLE : hue_quot;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hsv_valid_q <= 1'b0;
		end else if (en) begin
			hsv_valid_q <= valid_in;
		end
	end

	// Output register; saturation quotient never exceeds 255
	always_ff @(posedge clk) begin
		if (en) begin
			hsv_q.hue_out <= hue_wrapped;
			hsv_q.sat_out <= data_in.sat.nq[7:0];
			hsv_q.val_out <= data_in.val;
		end
	end

endmodule
